/* hw/rtl/lcd_mode_line_timing_top_assert.svh */
// ----------------------------------------------------------------------------
// LCD mode/line timing assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef LCD_MODE_LINE_TIMING_TOP_ASSERT_SVH
`define LCD_MODE_LINE_TIMING_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked outside reset.
`define LCDT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcd timing assertion failed");

// Next-cycle implication, checked outside reset.
`define LCDT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcd timing assertion failed");

`else

`define LCDT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LCDT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/lcdt_pkg.sv */
// ----------------------------------------------------------------------------
// LCD mode/line timing package
// Mode codes, timing constants, register map and field widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lcdt_pkg;

  localparam int unsigned DotsW  = 6;
  localparam int unsigned CntW   = 10;
  localparam int unsigned LineW  = 8;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  localparam logic [CntW-1:0]  DotsOam    = CntW'(80);
  localparam logic [CntW-1:0]  DotsXfer   = CntW'(172);
  localparam logic [CntW-1:0]  DotsHblank = CntW'(204);
  localparam logic [CntW-1:0]  DotsLine   = CntW'(456);
  localparam logic [CntW-1:0]  CntMax     = '1;
  localparam logic [LineW-1:0] LineVblank = LineW'(144);
  localparam logic [LineW-1:0] LineLast   = LineW'(153);

  typedef enum logic [ModeW-1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } mode_t;

  // Register index, taken from paddr[4:2]
  typedef enum logic [2:0] {
    REG_DISPLAY_ON  = 3'd0,
    REG_OAM_IRQ_EN  = 3'd1,
    REG_HBL_IRQ_EN  = 3'd2,
    REG_VBL_IRQ_EN  = 3'd3,
    REG_COIN_IRQ_EN = 3'd4,
    REG_LINE_CMP    = 3'd5
  } reg_idx_t;

endpackage

/* hw/rtl/lcdt_if.sv */
// ----------------------------------------------------------------------------
// LCD mode/line timing channels
// Valid/ready channels for dot-count items and timing result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lcdt_in_if;
  logic                         valid;
  logic                         ready;
  logic [lcdt_pkg::DotsW-1:0]   dots;

  modport source (output valid, output dots, input ready);
  modport sink   (input valid, input dots, output ready);
endinterface

interface lcdt_out_if;
  logic                         valid;
  logic                         ready;
  logic [lcdt_pkg::ModeW-1:0]   mode;
  logic [lcdt_pkg::LineW-1:0]   line;
  logic                         status_irq;
  logic                         vblank_irq;
  logic                         render_line;
  logic                         coincidence;

  modport source (output valid, output mode, output line, output status_irq,
                  output vblank_irq, output render_line, output coincidence,
                  input ready);
  modport sink   (input valid, input mode, input line, input status_irq,
                  input vblank_irq, input render_line, input coincidence,
                  output ready);
endinterface

/* hw/rtl/lcd_mode_line_timing_top.sv */
// ----------------------------------------------------------------------------
// LCD mode and line timing generator
// Dot counter, mode sequencer (OAM, transfer, hblank, vblank) and line counter
// with status/vblank interrupt requests and compare against line_compare.
// ----------------------------------------------------------------------------
//
//   channel   | direction | handshake           | payload
//   ----------+-----------+---------------------+------------------------------
//   in_ch     | sink      | valid/ready         | dots[5:0]
//   out_ch    | source    | valid/ready         | mode, line, irqs, render, coin
//   APB       | slave     | psel/penable/pready | paddr[4:0], pwdata/prdata[31:0]
//
// One item per cycle sustained while results are taken; each item passes an
// input register and then the result register.
// The dot counter, mode and line update once per item, in the result stage,
// with one add, one compare-and-subtract and one line increment.
// Reset (rst_n low, synchronous) clears config registers, timing state and both valids.
// A stalled result holds both stages; in_ch.ready drops only when both are full
// and the result is not taken. Register writes complete in the APB access cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lcd_mode_line_timing_top_assert.svh"

module lcd_mode_line_timing_top (
  input  logic                         clk,
  input  logic                         rst_n,
  lcdt_in_if.sink                      in_ch,
  lcdt_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lcdt_pkg::AddrW-1:0]   paddr,
  input  logic [lcdt_pkg::DataW-1:0]   pwdata,
  output logic [lcdt_pkg::DataW-1:0]   prdata,
  output logic                         pready
);

  // Configuration registers
  logic                         display_on_r;
  logic                         oam_irq_en_r;
  logic                         hbl_irq_en_r;
  logic                         vbl_irq_en_r;
  logic                         coin_irq_en_r;
  logic [lcdt_pkg::LineW-1:0]   line_cmp_r;

  // Input stage
  logic                         s1_valid_r;
  logic [lcdt_pkg::DotsW-1:0]   s1_dots_r;

  // Timing state
  logic [lcdt_pkg::CntW-1:0]    cnt_r,  cnt_nxt;
  lcdt_pkg::mode_t              mode_r, mode_nxt;
  logic [lcdt_pkg::LineW-1:0]   line_r, line_nxt;

  // Result stage
  logic                         out_valid_r;
  logic                         stat_irq_r, stat_nxt;
  logic                         vbl_irq_r,  vbl_nxt;
  logic                         render_r,   render_nxt;
  logic                         coin_r;

  logic                         cfg_wr;
  lcdt_pkg::reg_idx_t           cfg_idx;
  logic                         adv;
  logic [lcdt_pkg::CntW:0]      sum;
  logic [lcdt_pkg::CntW-1:0]    cnt_sat;
  logic [lcdt_pkg::LineW-1:0]   line_inc;

  // --------------------------------------------------------------------------
  // APB register file
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = lcdt_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_on_r  <= 1'b0;
      oam_irq_en_r  <= 1'b0;
      hbl_irq_en_r  <= 1'b0;
      vbl_irq_en_r  <= 1'b0;
      coin_irq_en_r <= 1'b0;
      line_cmp_r    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        lcdt_pkg::REG_DISPLAY_ON:  display_on_r  <= pwdata[0];
        lcdt_pkg::REG_OAM_IRQ_EN:  oam_irq_en_r  <= pwdata[0];
        lcdt_pkg::REG_HBL_IRQ_EN:  hbl_irq_en_r  <= pwdata[0];
        lcdt_pkg::REG_VBL_IRQ_EN:  vbl_irq_en_r  <= pwdata[0];
        lcdt_pkg::REG_COIN_IRQ_EN: coin_irq_en_r <= pwdata[0];
        lcdt_pkg::REG_LINE_CMP:    line_cmp_r    <= pwdata[lcdt_pkg::LineW-1:0];
        default: ;  // unmapped addresses drop the write
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      lcdt_pkg::REG_DISPLAY_ON:  prdata[0] = display_on_r;
      lcdt_pkg::REG_OAM_IRQ_EN:  prdata[0] = oam_irq_en_r;
      lcdt_pkg::REG_HBL_IRQ_EN:  prdata[0] = hbl_irq_en_r;
      lcdt_pkg::REG_VBL_IRQ_EN:  prdata[0] = vbl_irq_en_r;
      lcdt_pkg::REG_COIN_IRQ_EN: prdata[0] = coin_irq_en_r;
      lcdt_pkg::REG_LINE_CMP:    prdata[lcdt_pkg::LineW-1:0] = line_cmp_r;
      default:                   prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline flow: advance stage 1 into the result register whenever the
  // result register is empty or being taken this cycle.
  // --------------------------------------------------------------------------
  assign adv         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_dots_r <= in_ch.dots;
    end
  end

  // --------------------------------------------------------------------------
  // Mode step: add the elapsed dots (saturating), then at most one transition
  // --------------------------------------------------------------------------
  assign sum      = {1'b0, cnt_r} + {{(lcdt_pkg::CntW + 1 - lcdt_pkg::DotsW){1'b0}}, s1_dots_r};
  assign cnt_sat  = sum[lcdt_pkg::CntW] ? lcdt_pkg::CntMax : sum[lcdt_pkg::CntW-1:0];
  assign line_inc = line_r + 8'd1;

  always_comb begin
    cnt_nxt    = cnt_sat;
    mode_nxt   = mode_r;
    line_nxt   = line_r;
    stat_nxt   = 1'b0;
    vbl_nxt    = 1'b0;
    render_nxt = 1'b0;
    if (!display_on_r) begin
      // Display off: hold everything at zero, no requests
      cnt_nxt  = '0;
      mode_nxt = lcdt_pkg::MODE_HBLANK;
      line_nxt = '0;
    end else begin
      unique case (mode_r)
        lcdt_pkg::MODE_OAM: begin
          if (cnt_sat >= lcdt_pkg::DotsOam) begin
            cnt_nxt  = cnt_sat - lcdt_pkg::DotsOam;
            mode_nxt = lcdt_pkg::MODE_XFER;
            stat_nxt = oam_irq_en_r;
          end
        end
        lcdt_pkg::MODE_XFER: begin
          if (cnt_sat >= lcdt_pkg::DotsXfer) begin
            cnt_nxt    = cnt_sat - lcdt_pkg::DotsXfer;
            mode_nxt   = lcdt_pkg::MODE_HBLANK;
            render_nxt = 1'b1;
          end
        end
        lcdt_pkg::MODE_HBLANK: begin
          if (cnt_sat >= lcdt_pkg::DotsHblank) begin
            cnt_nxt  = cnt_sat - lcdt_pkg::DotsHblank;
            line_nxt = line_inc;
            stat_nxt = hbl_irq_en_r || (coin_irq_en_r && line_inc == line_cmp_r);
            if (line_inc == lcdt_pkg::LineVblank) begin
              vbl_nxt  = 1'b1;
              mode_nxt = lcdt_pkg::MODE_VBLANK;
            end else begin
              mode_nxt = lcdt_pkg::MODE_OAM;
            end
          end
        end
        lcdt_pkg::MODE_VBLANK: begin
          if (cnt_sat >= lcdt_pkg::DotsLine) begin
            cnt_nxt  = cnt_sat - lcdt_pkg::DotsLine;
            line_nxt = line_inc;
            stat_nxt = vbl_irq_en_r || (coin_irq_en_r && line_inc == line_cmp_r);
            if (line_inc > lcdt_pkg::LineLast) begin
              // Frame wrap: the line write to zero is compared as well
              mode_nxt = lcdt_pkg::MODE_OAM;
              line_nxt = '0;
              if (coin_irq_en_r && line_cmp_r == '0) begin
                stat_nxt = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // State and result registers, updated once per item
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      mode_r      <= lcdt_pkg::MODE_HBLANK;
      line_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        cnt_r  <= cnt_nxt;
        mode_r <= mode_nxt;
        line_r <= line_nxt;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stat_irq_r <= stat_nxt;
      vbl_irq_r  <= vbl_nxt;
      render_r   <= render_nxt;
      coin_r     <= (line_nxt == line_cmp_r);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.mode        = mode_r;
  assign out_ch.line        = line_r;
  assign out_ch.status_irq  = stat_irq_r;
  assign out_ch.vblank_irq  = vbl_irq_r;
  assign out_ch.render_line = render_r;
  assign out_ch.coincidence = coin_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `LCDT_ASSERT_IMP(a_line_range, clk, rst_n, 1'b1, line_r <= lcdt_pkg::LineLast)
  `LCDT_ASSERT_IMP(a_render_hblank, clk, rst_n, out_valid_r && render_r,
                   mode_r == lcdt_pkg::MODE_HBLANK)
  `LCDT_ASSERT_IMP(a_vbl_entry, clk, rst_n, out_valid_r && vbl_irq_r,
                   mode_r == lcdt_pkg::MODE_VBLANK && line_r == lcdt_pkg::LineVblank)
  `LCDT_ASSERT_NXT(a_display_off_clear, clk, rst_n, adv && !display_on_r,
                   cnt_r == '0 && line_r == '0 && mode_r == lcdt_pkg::MODE_HBLANK)

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// LCD mode and line timing testbench
// Streams dot-count items through the timing generator under random
// backpressure and phase-by-phase register settings, predicts mode, line,
// interrupt, render and compare results, and checks every result item in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import lcdt_pkg::*;

  // Expected contents of one result item
  typedef struct packed {
    mode_t            mode;
    logic [LineW-1:0] line;
    logic             status_irq;
    logic             vblank_irq;
    logic             render_line;
    logic             coincidence;
  } timing_result_t;

  // Mode/line timing predictor plus the queue of results still owed by the block
  class lcd_timing_scoreboard;
    logic             disp_on;
    logic             oam_en;
    logic             hbl_en;
    logic             vbl_en;
    logic             coin_en;
    logic [LineW-1:0] cmp_line;

    logic [CntW-1:0]  dot_cnt;
    mode_t            cur_mode;
    logic [LineW-1:0] cur_line;

    timing_result_t   owed_q[$];
    int unsigned      errors;

    function new();
      disp_on  = 1'b0;
      oam_en   = 1'b0;
      hbl_en   = 1'b0;
      vbl_en   = 1'b0;
      coin_en  = 1'b0;
      cmp_line = '0;
      dot_cnt  = '0;
      cur_mode = MODE_HBLANK;
      cur_line = '0;
      errors   = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [DataW-1:0] value);
      case (idx)
        REG_DISPLAY_ON:  disp_on  = value[0];
        REG_OAM_IRQ_EN:  oam_en   = value[0];
        REG_HBL_IRQ_EN:  hbl_en   = value[0];
        REG_VBL_IRQ_EN:  vbl_en   = value[0];
        REG_COIN_IRQ_EN: coin_en  = value[0];
        REG_LINE_CMP:    cmp_line = value[LineW-1:0];
        default: ;
      endcase
    endfunction

    // Advance the line and report whether the compare interrupt fires
    function logic bump_line(logic [LineW-1:0] next_line);
      cur_line = next_line;
      return coin_en && (cur_line == cmp_line);
    endfunction

    function void note_dots(logic [DotsW-1:0] dots);
      int unsigned    acc;
      timing_result_t exp_res;
      acc = dot_cnt + dots;
      exp_res = '0;
      if (!disp_on) begin
        cur_mode = MODE_HBLANK;
        cur_line = '0;
        dot_cnt  = '0;
      end else begin
        if (acc > CntMax) acc = CntMax;
        case (cur_mode)
          MODE_OAM: begin
            if (acc >= DotsOam) begin
              acc -= DotsOam;
              cur_mode = MODE_XFER;
              if (oam_en) exp_res.status_irq = 1'b1;
            end
          end
          MODE_XFER: begin
            if (acc >= DotsXfer) begin
              acc -= DotsXfer;
              cur_mode = MODE_HBLANK;
              exp_res.render_line = 1'b1;
            end
          end
          MODE_HBLANK: begin
            if (acc >= DotsHblank) begin
              acc -= DotsHblank;
              if (bump_line(cur_line + 1'b1)) exp_res.status_irq = 1'b1;
              if (cur_line == LineVblank) begin
                exp_res.vblank_irq = 1'b1;
                cur_mode = MODE_VBLANK;
              end else begin
                cur_mode = MODE_OAM;
              end
              if (hbl_en) exp_res.status_irq = 1'b1;
            end
          end
          default: begin
            if (acc >= DotsLine) begin
              acc -= DotsLine;
              if (bump_line(cur_line + 1'b1)) exp_res.status_irq = 1'b1;
              if (cur_line > LineLast) begin
                cur_mode = MODE_OAM;
                if (bump_line('0)) exp_res.status_irq = 1'b1;
              end
              if (vbl_en) exp_res.status_irq = 1'b1;
            end
          end
        endcase
        dot_cnt = acc[CntW-1:0];
      end
      exp_res.mode        = cur_mode;
      exp_res.line        = cur_line;
      exp_res.coincidence = (cur_line == cmp_line);
      owed_q.push_back(exp_res);
    endfunction

    function void check_result(timing_result_t got);
      timing_result_t exp_res;
      if (owed_q.size() == 0) begin
        $error("result item arrived with none expected");
        errors++;
        return;
      end
      exp_res = owed_q.pop_front();
      if (got.mode !== exp_res.mode) begin
        $error("mode: expected %0d, got %0d", exp_res.mode, got.mode);
        errors++;
      end
      if (got.line !== exp_res.line) begin
        $error("line: expected %0d, got %0d", exp_res.line, got.line);
        errors++;
      end
      if (got.status_irq !== exp_res.status_irq) begin
        $error("status_irq: expected %0b, got %0b", exp_res.status_irq, got.status_irq);
        errors++;
      end
      if (got.vblank_irq !== exp_res.vblank_irq) begin
        $error("vblank_irq: expected %0b, got %0b", exp_res.vblank_irq, got.vblank_irq);
        errors++;
      end
      if (got.render_line !== exp_res.render_line) begin
        $error("render_line: expected %0b, got %0b", exp_res.render_line,
               got.render_line);
        errors++;
      end
      if (got.coincidence !== exp_res.coincidence) begin
        $error("coincidence: expected %0b, got %0b", exp_res.coincidence,
               got.coincidence);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  localparam int unsigned IdleLimit   = 2000; // cycles without any handshake
  localparam int unsigned StallCycles = 64;   // long receiver hold-off
  localparam int unsigned PhaseItems  = 200;
  localparam int unsigned OffItems    = 40;
  localparam int unsigned NumPhases   = 8;

  logic             clk;
  logic             rst_n;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  lcdt_in_if  in_if ();
  lcdt_out_if out_if ();

  lcd_timing_scoreboard sb = new();

  // Idle bounds per side, changed between phases; zero means full rate
  int unsigned src_gap_max  = 8;
  int unsigned sink_gap_max = 8;
  // Set by the stimulus to make the receiver hold off for a long stretch
  bit          stall_request = 1'b0;
  int unsigned reg_errors    = 0;

  lcd_mode_line_timing_top DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: end the run if no item moves on either channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= IdleLimit) begin
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  // Result receiver: check each accepted item, then draw the wait before the next.
  // A stall request overrides the random wait with one long hold-off.
  initial begin : result_sink
    int unsigned    wait_left;
    int unsigned    hold_left;
    timing_result_t got;
    wait_left = 0;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        got.mode        = mode_t'(out_if.mode);
        got.line        = out_if.line;
        got.status_irq  = out_if.status_irq;
        got.vblank_irq  = out_if.vblank_irq;
        got.render_line = out_if.render_line;
        got.coincidence = out_if.coincidence;
        sb.check_result(got);
        wait_left = $urandom_range(0, sink_gap_max);
      end
      if (stall_request) begin
        hold_left     = StallCycles;
        stall_request = 1'b0;
      end
      // Exactly one assignment to ready per edge
      if (!rst_n) begin
        out_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (wait_left > 0) begin
        wait_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Offer one dot-count item after a random gap; return at the edge it is taken.
  // Valid is left high so a back-to-back item needs no extra edge.
  task automatic offer_dots(input logic [DotsW-1:0] dots);
    int unsigned gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.dots  <= dots;
    do @(posedge clk); while (!in_if.ready);
    sb.note_dots(dots);
  endtask

  // Drop valid and hold until every owed result has come back, then settle
  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write followed by a read-back of the same register
  task automatic write_register(input reg_idx_t idx, input logic [DataW-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // Keep psel high and go straight into the read setup phase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) begin
      $error("register %s: expected %0h, got %0h", idx.name(), value, prdata);
      reg_errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  // Mostly near-maximal dot counts so the run covers whole frames, with
  // some zero and full-range counts mixed in
  function automatic logic [DotsW-1:0] pick_dots();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return '0;
    if (roll < 15) return DotsW'($urandom_range(0, 63));
    return DotsW'($urandom_range(56, 63));
  endfunction

  // Display-off items, then the opening of the first visible line:
  // hblank to line 1, OAM scan, pixel transfer, hblank with render request
  int unsigned off_dots[4]   = '{0, 63, 42, 21};
  int unsigned first_line[9] = '{63, 63, 63, 15, 63, 17, 63, 63, 46};

  initial begin : stimulus
    int unsigned      n_items;
    logic [LineW-1:0] cmp_val;
    rst_n       <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_if.valid <= 1'b0;
    in_if.dots  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Display off after reset: everything held at zero, line 0 matches compare 0
    foreach (off_dots[i]) offer_dots(DotsW'(off_dots[i]));
    wait_for_results();
    write_register(REG_LINE_CMP, 32'd255);
    offer_dots(DotsW'(63));
    wait_for_results();

    // Enable every interrupt source, compare on line 1, then turn the display on
    write_register(REG_OAM_IRQ_EN, 32'd1);
    write_register(REG_HBL_IRQ_EN, 32'd1);
    write_register(REG_VBL_IRQ_EN, 32'd1);
    write_register(REG_COIN_IRQ_EN, 32'd1);
    write_register(REG_LINE_CMP, 32'd1);
    write_register(REG_DISPLAY_ON, 32'd1);
    foreach (first_line[i]) offer_dots(DotsW'(first_line[i]));
    offer_dots('0);
    wait_for_results();

    // Random phases; the display stays on so timing runs through whole frames,
    // and only the last phase turns it off again
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0:       cmp_val = 8'd255;
        1:       cmp_val = 8'd144;
        2:       cmp_val = 8'd0;
        3:       cmp_val = 8'd153;
        default: cmp_val = LineW'($urandom_range(0, 153));
      endcase
      if (ph == 2) begin
        write_register(REG_OAM_IRQ_EN, 32'd1);
        write_register(REG_HBL_IRQ_EN, 32'd1);
        write_register(REG_VBL_IRQ_EN, 32'd1);
        write_register(REG_COIN_IRQ_EN, 32'd1);
      end else if (ph == 3) begin
        write_register(REG_OAM_IRQ_EN, 32'd0);
        write_register(REG_HBL_IRQ_EN, 32'd0);
        write_register(REG_VBL_IRQ_EN, 32'd0);
        write_register(REG_COIN_IRQ_EN, 32'd0);
      end else begin
        write_register(REG_OAM_IRQ_EN, DataW'($urandom_range(0, 1)));
        write_register(REG_HBL_IRQ_EN, DataW'($urandom_range(0, 1)));
        write_register(REG_VBL_IRQ_EN, DataW'($urandom_range(0, 1)));
        write_register(REG_COIN_IRQ_EN, DataW'($urandom_range(0, 1)));
      end
      write_register(REG_LINE_CMP, DataW'(cmp_val));
      write_register(REG_DISPLAY_ON, (ph == NumPhases - 1) ? 32'd0 : 32'd1);

      // Phase 4: sender at full rate against a long receiver hold-off,
      // so both stages fill and the input stalls. Phase 5: both at full rate.
      src_gap_max  = (ph == 4 || ph == 5) ? 0 : 8;
      sink_gap_max = (ph == 5 || ph == 6) ? 0 : 8;
      if (ph == 4) stall_request = 1'b1;

      n_items = (ph == NumPhases - 1) ? OffItems : PhaseItems;
      for (int k = 0; k < n_items; k++) offer_dots(pick_dots());
      wait_for_results();
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && reg_errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
